// ----- sv/sns_pkg.sv -----
// ----------------------------------------------------------------------------
// sns_pkg
// Shared types and constants of the storage node selector.
// ----------------------------------------------------------------------------
package sns_pkg;

   localparam int unsigned MAX_NODES_DEFAULT = 16;

   localparam int unsigned CMD_W       = 3;
   localparam int unsigned INDEX_W     = 4;
   localparam int unsigned FREE_W      = 16;
   localparam int unsigned STATUS_W    = 2;
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 16;

   // Selection modes held in the select_mode register.
   localparam logic EL  = 1'b0;
   localparam logic LSU = 1'b1;

   typedef enum logic [CMD_W-1:0] {
      CMD_REGISTER     = 3'd0,
      CMD_RECONNECT    = 3'd1,
      CMD_DISCONNECT   = 3'd2,
      CMD_SET_FREE     = 3'd3,
      CMD_SELECT       = 3'd4,
      CMD_TRIAL_SELECT = 3'd5
   } command_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_NONE  = 2'd1,
      STATUS_FULL  = 2'd2,
      STATUS_UNREG = 2'd3
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SELECT_MODE  = 1'b0,
      CSR_INITIAL_FREE = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MODIFY,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              connected;
      logic [FREE_W-1:0] free;
   } node_entry_type;

endpackage

// ----- sv/storage_node_selector.sv -----
// ----------------------------------------------------------------------------
// storage_node_selector
// Node table with round-robin and most-free-space target selection.
//
// The node table (connected flag and free count per node) lives in a single
// synchronous RAM with a registered read port; the registered node count
// doubles as a fill count, so entries are only ever read after registration
// wrote them and no clearing pass is needed after reset. One transaction is
// processed at a time. Register, unused and rejected commands go from the
// accepting cycle straight to ST_DONE; reconnect, disconnect and set free
// pass through ST_MODIFY first (the entry is read in the accepting cycle,
// then modified and written back). ST_DONE loads the response into the
// output register once that register is free or being taken. Select and
// trial select read the table one entry per cycle through the RAM read port
// in ST_SCAN, which ends after the last registered node is checked; an
// equal-load select ends early at the first connected node it finds. The
// next transaction is accepted in ST_IDLE, after the response is loaded. It
// is accepted as soon as the previous response sits in the output register,
// even if it has not been taken yet.
// ----------------------------------------------------------------------------
module storage_node_selector #(
   parameter int unsigned MAX_NODES = sns_pkg::MAX_NODES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [sns_pkg::CMD_W-1:0]       req_command,
   input  logic [sns_pkg::INDEX_W-1:0]     req_node_index,
   input  logic [sns_pkg::FREE_W-1:0]      req_free_entries,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [sns_pkg::STATUS_W-1:0]    rsp_status,
   output logic [sns_pkg::INDEX_W-1:0]     rsp_chosen_index,
   output logic [sns_pkg::FREE_W-1:0]      rsp_chosen_free,
   input  logic                            csr_wr_en,
   input  logic [sns_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sns_pkg::CSR_DATA_W-1:0]  csr_wr_data
);
   import sns_pkg::*;

   localparam int unsigned IDX_W = $clog2(MAX_NODES);
   localparam int unsigned CNT_W = $clog2(MAX_NODES + 1);
   localparam int unsigned CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

   function automatic logic [IDX_W-1:0] next_after(input logic [IDX_W-1:0] i,
                                                   input logic [CNT_W-1:0] n);
      logic [CNT_W-1:0] inc;
      inc = CNT_W'(i) + CNT_W'(1);
      return (inc >= n) ? '0 : IDX_W'(inc);
   endfunction

   // Node table RAM.
   node_entry_type node_mem [MAX_NODES];
   logic           rd_en;
   logic [IDX_W-1:0] rd_addr;
   node_entry_type rd_data_ff;
   logic           wr_en;
   logic [IDX_W-1:0] wr_addr;
   node_entry_type wr_data;

   state_type        state_ff, state_in;
   logic             mode_ff, mode_in;
   logic [FREE_W-1:0] init_ff, init_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] ptr_ff, ptr_in;

   command_type      cmd_ff, cmd_in;
   logic [INDEX_W-1:0] idx_ff, idx_in;
   logic [FREE_W-1:0] fr_ff, fr_in;

   logic [IDX_W-1:0] start_ff, start_in;
   logic [IDX_W-1:0] scan_addr_ff, scan_addr_in;
   logic [CNT_W-1:0] issue_left_ff, issue_left_in;
   logic             rd_valid_ff, rd_valid_in;
   logic             rd_last_ff, rd_last_in;
   logic [IDX_W-1:0] rd_addr_q_ff, rd_addr_q_in;

   // Running most-free-space search.
   logic             any_ff, any_in;
   logic [FREE_W-1:0] best_ff, best_in;
   logic [IDX_W-1:0] first_ff, first_in;
   logic [IDX_W-1:0] at_ff, at_in;
   logic             have_at_ff, have_at_in;
   logic             multi_ff, multi_in;
   logic             lsu_any, lsu_have_at, lsu_multi;
   logic [FREE_W-1:0] lsu_best;
   logic [IDX_W-1:0] lsu_first, lsu_at, lsu_pick;

   status_type       res_status_ff, res_status_in;
   logic [INDEX_W-1:0] res_index_ff, res_index_in;
   logic [FREE_W-1:0] res_free_ff, res_free_in;

   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [FREE_W-1:0] rsp_free_ff, rsp_free_in;

   node_entry_type   mod_entry;

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_chosen_index = rsp_index_ff;
   assign rsp_chosen_free  = rsp_free_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= node_mem[rd_addr];
      end
   end

   // Entry after a reconnect, disconnect or set free.
   always_comb begin
      case (cmd_ff)
         CMD_RECONNECT:  mod_entry = '{connected: 1'b1, free: fr_ff};
         CMD_DISCONNECT: mod_entry = '{connected: 1'b0, free: rd_data_ff.free};
         default:        mod_entry = '{connected: rd_data_ff.connected, free: fr_ff};
      endcase
   end

   // One step of the most-free-space search, done in index order.
   always_comb begin
      lsu_any     = any_ff;
      lsu_best    = best_ff;
      lsu_first   = first_ff;
      lsu_at      = at_ff;
      lsu_have_at = have_at_ff;
      lsu_multi   = multi_ff;
      if (rd_data_ff.connected) begin
         if (!any_ff || rd_data_ff.free > best_ff) begin
            lsu_any     = 1'b1;
            lsu_best    = rd_data_ff.free;
            lsu_first   = rd_addr_q_ff;
            lsu_at      = rd_addr_q_ff;
            lsu_have_at = (rd_addr_q_ff >= start_ff);
            lsu_multi   = 1'b0;
         end else if (rd_data_ff.free == best_ff) begin
            lsu_multi = 1'b1;
            if (!have_at_ff && rd_addr_q_ff >= start_ff) begin
               lsu_have_at = 1'b1;
               lsu_at      = rd_addr_q_ff;
            end
         end
      end
      lsu_pick = lsu_have_at ? lsu_at : lsu_first;
   end

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      init_in       = init_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      cmd_in        = cmd_ff;
      idx_in        = idx_ff;
      fr_in         = fr_ff;
      start_in      = start_ff;
      scan_addr_in  = scan_addr_ff;
      issue_left_in = issue_left_ff;
      rd_valid_in   = 1'b0;
      rd_last_in    = rd_last_ff;
      rd_addr_q_in  = rd_addr_q_ff;
      any_in        = any_ff;
      best_in       = best_ff;
      first_in      = first_ff;
      at_in         = at_ff;
      have_at_in    = have_at_ff;
      multi_in      = multi_ff;
      res_status_in = res_status_ff;
      res_index_in  = res_index_ff;
      res_free_in   = res_free_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_free_in   = rsp_free_ff;
      rd_en         = 1'b0;
      rd_addr       = scan_addr_ff;
      wr_en         = 1'b0;
      wr_addr       = IDX_W'(idx_ff);
      wr_data       = mod_entry;

      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_SELECT_MODE:  mode_in = csr_wr_data[0];
            CSR_INITIAL_FREE: init_in = csr_wr_data;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in   = command_type'(req_command);
               idx_in   = req_node_index;
               fr_in    = req_free_entries;
               state_in = ST_DONE;
               unique case (command_type'(req_command)) inside
                  CMD_REGISTER: begin
                     if (count_ff == CNT_W'(MAX_NODES)) begin
                        res_status_in = STATUS_FULL;
                        res_index_in  = '0;
                        res_free_in   = '0;
                     end else begin
                        wr_en         = 1'b1;
                        wr_addr       = IDX_W'(count_ff);
                        wr_data       = '{connected: 1'b1, free: init_ff};
                        count_in      = count_ff + CNT_W'(1);
                        res_status_in = STATUS_OK;
                        res_index_in  = INDEX_W'(count_ff);
                        res_free_in   = init_ff;
                     end
                  end
                  CMD_RECONNECT, CMD_DISCONNECT, CMD_SET_FREE: begin
                     if (CMP_W'(req_node_index) >= CMP_W'(count_ff)) begin
                        res_status_in = STATUS_UNREG;
                        res_index_in  = req_node_index;
                        res_free_in   = '0;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = IDX_W'(req_node_index);
                        state_in = ST_MODIFY;
                     end
                  end
                  CMD_SELECT, CMD_TRIAL_SELECT: begin
                     if (count_ff == '0) begin
                        res_status_in = STATUS_NONE;
                        res_index_in  = '0;
                        res_free_in   = '0;
                     end else begin
                        // A stale pointer beyond the table restarts at node 0.
                        start_in      = (CNT_W'(ptr_ff) < count_ff) ? ptr_ff : '0;
                        scan_addr_in  = (mode_ff == LSU) ? '0 :
                                        ((CNT_W'(ptr_ff) < count_ff) ? ptr_ff : '0);
                        issue_left_in = count_ff;
                        any_in        = 1'b0;
                        have_at_in    = 1'b0;
                        multi_in      = 1'b0;
                        state_in      = ST_SCAN;
                     end
                  end
                  default: begin
                     res_status_in = STATUS_OK;
                     res_index_in  = '0;
                     res_free_in   = '0;
                  end
               endcase
            end
         end

         ST_MODIFY: begin
            wr_en         = 1'b1;
            res_status_in = STATUS_OK;
            res_index_in  = idx_ff;
            res_free_in   = mod_entry.free;
            state_in      = ST_DONE;
         end

         ST_SCAN: begin
            // Reads are issued back to back; the data of each returns through the registered read port.
            if (issue_left_ff != '0) begin
               rd_en         = 1'b1;
               rd_addr       = scan_addr_ff;
               rd_valid_in   = 1'b1;
               rd_last_in    = (issue_left_ff == CNT_W'(1));
               rd_addr_q_in  = scan_addr_ff;
               issue_left_in = issue_left_ff - CNT_W'(1);
               scan_addr_in  = next_after(scan_addr_ff, count_ff);
            end
            if (rd_valid_ff) begin
               if (mode_ff == EL) begin
                  if (rd_data_ff.connected) begin
                     res_status_in = STATUS_OK;
                     res_index_in  = INDEX_W'(rd_addr_q_ff);
                     res_free_in   = rd_data_ff.free;
                     if (cmd_ff == CMD_SELECT) begin
                        ptr_in = next_after(rd_addr_q_ff, count_ff);
                     end
                     state_in = ST_DONE;
                  end else if (rd_last_ff) begin
                     res_status_in = STATUS_NONE;
                     res_index_in  = '0;
                     res_free_in   = '0;
                     state_in      = ST_DONE;
                  end
               end else begin
                  any_in     = lsu_any;
                  best_in    = lsu_best;
                  first_in   = lsu_first;
                  at_in      = lsu_at;
                  have_at_in = lsu_have_at;
                  multi_in   = lsu_multi;
                  if (rd_last_ff) begin
                     state_in = ST_DONE;
                     if (lsu_any) begin
                        res_status_in = STATUS_OK;
                        res_index_in  = INDEX_W'(lsu_pick);
                        res_free_in   = lsu_best;
                        // The pointer only moves when several nodes share the maximum.
                        if (cmd_ff == CMD_SELECT && lsu_multi) begin
                           ptr_in = next_after(lsu_pick, count_ff);
                        end
                     end else begin
                        res_status_in = STATUS_NONE;
                        res_index_in  = '0;
                        res_free_in   = '0;
                     end
                  end
               end
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_index_in  = res_index_ff;
               rsp_free_in   = res_free_ff;
               state_in      = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= EL;
         init_ff      <= '0;
         count_ff     <= '0;
         ptr_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         init_ff      <= init_in;
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      idx_ff        <= idx_in;
      fr_ff         <= fr_in;
      start_ff      <= start_in;
      scan_addr_ff  <= scan_addr_in;
      issue_left_ff <= issue_left_in;
      rd_last_ff    <= rd_last_in;
      rd_addr_q_ff  <= rd_addr_q_in;
      any_ff        <= any_in;
      best_ff       <= best_in;
      first_ff      <= first_in;
      at_ff         <= at_in;
      have_at_ff    <= have_at_in;
      multi_ff      <= multi_in;
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      res_free_ff   <= res_free_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_free_ff   <= rsp_free_in;
   end

endmodule
